FILE: src/lbs_pkg.sv
// Shared types, constants and helper functions for the linear blend skinning core.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package lbs_pkg;

   localparam int DEF_JOINT_COUNT = 64;
   localparam int DEF_FRAC_BITS   = 16;
   localparam int WEIGHT_FRAC     = 15;
   localparam int ELEMS           = 16;
   localparam int REQ_DATA_W      = 328;
   localparam int RSP_DATA_W      = 192;

   typedef enum logic [1:0] {
      KIND_INV_BIND = 2'd0,
      KIND_POSE     = 2'd1,
      KIND_VERTEX   = 2'd2
   } kind_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] nrm_x;
      logic signed [31:0] nrm_y;
      logic signed [31:0] nrm_z;
   } vertex_type;

   // Side information that travels with one joint influence.
   typedef struct packed {
      logic        first;
      logic        last;
      logic        live;
      logic [15:0] weight;
   } infl_type;

   localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
   localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) begin
         r = 32'sh7FFFFFFF;
      end else if (v < SAT_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: src/lbs_joint_store.sv
// One joint matrix store: sixteen element lanes, each a memory of one word per joint.
// Depends on lbs_pkg.
`default_nettype none
module lbs_joint_store
   import lbs_pkg::*;
#(
   parameter int JOINT_COUNT = DEF_JOINT_COUNT
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [7:0]          wr_joint,
   input  wire logic [3:0]          wr_elem,
   input  wire logic signed [31:0]  wr_data,
   input  wire logic                rd_en,
   input  wire logic [7:0]          rd_joint,
   output logic signed [31:0]       rd_data [ELEMS]
);
   localparam int JW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

   logic signed [31:0] mem [JOINT_COUNT][ELEMS];
   logic [JW-1:0] wa, ra;

   assign wa = wr_joint[JW-1:0];
   assign ra = rd_joint[JW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wa][wr_elem] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         for (int e = 0; e < ELEMS; e++) begin
            rd_data[e] <= mem[ra][e];
         end
      end
   end
endmodule
`default_nettype wire

FILE: src/lbs_matmul.sv
// Per-influence pipeline: 64 element products, row sums with saturation, weighting.
// Depends on lbs_pkg.
`default_nettype none
module lbs_matmul
   import lbs_pkg::*;
#(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic signed [31:0] in_a [ELEMS],
   input  wire logic signed [31:0] in_b [ELEMS],
   input  wire infl_type           in_infl,
   input  wire vertex_type         in_vtx,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output logic signed [33:0]      out_term [ELEMS],
   output infl_type                out_infl,
   output vertex_type              out_vtx
);
   // Stage 1: truncated products a[r][k] * b[k][c].
   logic               p_v_ff;
   logic signed [63:0] prod_ff [ELEMS][4];
   infl_type           p_infl_ff;
   vertex_type         p_vtx_ff;
   // Stage 2: saturated element sums.
   logic               s_v_ff;
   logic signed [31:0] sum_ff [ELEMS];
   infl_type           s_infl_ff;
   vertex_type         s_vtx_ff;
   // Stage 3: weighted terms.
   logic               w_v_ff;
   logic signed [33:0] term_ff [ELEMS];
   infl_type           w_infl_ff;
   vertex_type         w_vtx_ff;

   logic p_rdy, s_rdy, w_rdy;
   assign w_rdy    = !w_v_ff || out_ready;
   assign s_rdy    = !s_v_ff || w_rdy;
   assign p_rdy    = !p_v_ff || s_rdy;
   assign in_ready = p_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
         s_v_ff <= 1'b0;
         w_v_ff <= 1'b0;
      end else begin
         if (p_rdy) p_v_ff <= in_valid;
         if (s_rdy) s_v_ff <= p_v_ff;
         if (w_rdy) w_v_ff <= s_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (p_rdy && in_valid) begin
         for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
               for (int k = 0; k < 4; k++) begin
                  prod_ff[r*4+c][k] <= (64'(in_a[r*4+k]) * 64'(in_b[k*4+c])) >>> FRAC_BITS;
               end
            end
         end
         p_infl_ff <= in_infl;
         p_vtx_ff  <= in_vtx;
      end
      if (s_rdy && p_v_ff) begin
         for (int e = 0; e < ELEMS; e++) begin
            sum_ff[e] <= sat32(66'(prod_ff[e][0]) + 66'(prod_ff[e][1])
                              + 66'(prod_ff[e][2]) + 66'(prod_ff[e][3]));
         end
         s_infl_ff <= p_infl_ff;
         s_vtx_ff  <= p_vtx_ff;
      end
      if (w_rdy && s_v_ff) begin
         for (int e = 0; e < ELEMS; e++) begin
            if (s_infl_ff.live) begin
               term_ff[e] <= 34'((49'(sum_ff[e]) * $signed({1'b0, s_infl_ff.weight}))
                                 >>> WEIGHT_FRAC);
            end else begin
               term_ff[e] <= '0;
            end
         end
         w_infl_ff <= s_infl_ff;
         w_vtx_ff  <= s_vtx_ff;
      end
   end

   assign out_valid = w_v_ff;
   assign out_term  = term_ff;
   assign out_infl  = w_infl_ff;
   assign out_vtx   = w_vtx_ff;
endmodule
`default_nettype wire

FILE: src/lbs_xform.sv
// Transform stage: saturates the skin matrix, multiplies position and normal, and
// holds the result in the output register. Depends on lbs_pkg.
`default_nettype none
module lbs_xform
   import lbs_pkg::*;
#(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic signed [35:0] in_acc [ELEMS],
   input  wire vertex_type         in_vtx,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output vertex_type              out_res
);
   logic               m_v_ff;
   logic signed [63:0] pp_ff [3][3];
   logic signed [63:0] np_ff [3][3];
   logic signed [31:0] tr_ff [3];
   logic               o_v_ff;
   vertex_type         res_ff;

   logic signed [31:0] skin [ELEMS];
   logic signed [63:0] pv [3];
   logic signed [63:0] nv [3];
   logic m_rdy, o_rdy;

   assign o_rdy    = !o_v_ff || out_ready;
   assign m_rdy    = !m_v_ff || o_rdy;
   assign in_ready = m_rdy;

   always_comb begin
      for (int e = 0; e < ELEMS; e++) begin
         skin[e] = sat32(66'(in_acc[e]));
      end
      pv[0] = 64'(in_vtx.pos_x);
      pv[1] = 64'(in_vtx.pos_y);
      pv[2] = 64'(in_vtx.pos_z);
      nv[0] = 64'(in_vtx.nrm_x);
      nv[1] = 64'(in_vtx.nrm_y);
      nv[2] = 64'(in_vtx.nrm_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else begin
         if (m_rdy) m_v_ff <= in_valid;
         if (o_rdy) o_v_ff <= m_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (m_rdy && in_valid) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               pp_ff[r][c] <= (pv[r] * 64'(skin[r*4+c])) >>> FRAC_BITS;
               np_ff[r][c] <= (nv[r] * 64'(skin[r*4+c])) >>> FRAC_BITS;
            end
         end
         for (int c = 0; c < 3; c++) begin
            tr_ff[c] <= skin[12+c];
         end
      end
      if (o_rdy && m_v_ff) begin
         res_ff.pos_x <= sat32(66'(pp_ff[0][0]) + 66'(pp_ff[1][0]) + 66'(pp_ff[2][0])
                              + 66'(tr_ff[0]));
         res_ff.pos_y <= sat32(66'(pp_ff[0][1]) + 66'(pp_ff[1][1]) + 66'(pp_ff[2][1])
                              + 66'(tr_ff[1]));
         res_ff.pos_z <= sat32(66'(pp_ff[0][2]) + 66'(pp_ff[1][2]) + 66'(pp_ff[2][2])
                              + 66'(tr_ff[2]));
         res_ff.nrm_x <= sat32(66'(np_ff[0][0]) + 66'(np_ff[1][0]) + 66'(np_ff[2][0]));
         res_ff.nrm_y <= sat32(66'(np_ff[0][1]) + 66'(np_ff[1][1]) + 66'(np_ff[2][1]));
         res_ff.nrm_z <= sat32(66'(np_ff[0][2]) + 66'(np_ff[1][2]) + 66'(np_ff[2][2]));
      end
   end

   assign out_valid = o_v_ff;
   assign out_res   = res_ff;
endmodule
`default_nettype wire

FILE: src/linear_blend_vertex_skinning_core.sv
// Linear blend skinning core with four joint influences, Q16.16 fixed point.
// Throughput: a load word every cycle while the sequencer is idle; a load or
// vertex word is also taken as the last influence issues. One joint influence
// is issued per cycle, stalls apart, through a single matrix product pipeline.
// Reset (synchronous, active high) clears all valid and sequencer state; the joint
// stores are not cleared and must be loaded before a vertex uses them.
`default_nettype none
module linear_blend_vertex_skinning_core
   import lbs_pkg::*;
#(
   parameter int JOINT_COUNT = DEF_JOINT_COUNT,
   parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // Fields from bit 0 up: pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, weights_packed,
   // joints_packed, entry_joint, entry_element, entry_value, zero fill.
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // Fields from bit 0 up: kind.
   input  wire logic [1:0]            req_tuser,
   // Response channel.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // Fields from bit 0 up: out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y,
   // out_nrm_z.
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);
   // Unpack the request word.
   vertex_type         req_vtx;
   logic [63:0]        req_weights;
   logic [23:0]        req_joints;
   logic [5:0]         req_joint;
   logic [3:0]         req_elem;
   logic signed [31:0] req_value;
   logic               accept;

   assign req_vtx.pos_x = req_tdata[31:0];
   assign req_vtx.pos_y = req_tdata[63:32];
   assign req_vtx.pos_z = req_tdata[95:64];
   assign req_vtx.nrm_x = req_tdata[127:96];
   assign req_vtx.nrm_y = req_tdata[159:128];
   assign req_vtx.nrm_z = req_tdata[191:160];
   assign req_weights   = req_tdata[255:192];
   assign req_joints    = req_tdata[279:256];
   assign req_joint     = req_tdata[285:280];
   assign req_elem      = req_tdata[289:286];
   assign req_value     = req_tdata[321:290];

   assign accept  = req_tvalid && req_tready;

   // The influence sequencer holds one vertex and issues one influence per cycle while the read stage is ready.
   logic        busy_ff, busy_in;
   logic [1:0]  inf_ff, inf_in;
   vertex_type  vtx_ff;
   logic [63:0] wts_ff;
   logic [23:0] jts_ff;
   logic        s1_rdy;
   logic        issue;
   logic [5:0]  cur_joint;
   infl_type    cur_infl;
   logic        joint_ok;

   assign issue      = busy_ff && s1_rdy;
   assign req_tready = !busy_ff || ((inf_ff == 2'd3) && s1_rdy);
   assign cur_joint  = jts_ff[6*inf_ff +: 6];
   assign joint_ok   = 9'(req_joint) < 9'(JOINT_COUNT);

   always_comb begin
      cur_infl.first  = (inf_ff == 2'd0);
      cur_infl.last   = (inf_ff == 2'd3);
      cur_infl.live   = 9'(cur_joint) < 9'(JOINT_COUNT);
      cur_infl.weight = wts_ff[16*inf_ff +: 16];
      busy_in = busy_ff;
      inf_in  = inf_ff;
      if (issue) begin
         inf_in = inf_ff + 2'd1;
         if (inf_ff == 2'd3) busy_in = 1'b0;
      end
      if (accept && (req_tuser == KIND_VERTEX)) begin
         busy_in = 1'b1;
         inf_in  = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         inf_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         inf_ff  <= inf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req_tuser == KIND_VERTEX)) begin
         vtx_ff <= req_vtx;
         wts_ff <= req_weights;
         jts_ff <= req_joints;
      end
   end

   // Joint stores; a load is written in the cycle its word is accepted.
   logic signed [31:0] ib_data [ELEMS];
   logic signed [31:0] ps_data [ELEMS];

   lbs_joint_store #(.JOINT_COUNT(JOINT_COUNT)) u_inv_bind (
      .clock    (clock),
      .wr_en    (accept && joint_ok && (req_tuser == KIND_INV_BIND)),
      .wr_joint (8'(req_joint)),
      .wr_elem  (req_elem),
      .wr_data  (req_value),
      .rd_en    (issue),
      .rd_joint (8'(cur_joint)),
      .rd_data  (ib_data)
   );

   lbs_joint_store #(.JOINT_COUNT(JOINT_COUNT)) u_pose (
      .clock    (clock),
      .wr_en    (accept && joint_ok && (req_tuser == KIND_POSE)),
      .wr_joint (8'(req_joint)),
      .wr_elem  (req_elem),
      .wr_data  (req_value),
      .rd_en    (issue),
      .rd_joint (8'(cur_joint)),
      .rd_data  (ps_data)
   );

   // The read stage: store outputs are registered, side information follows.
   logic       s1_v_ff;
   infl_type   s1_infl_ff;
   vertex_type s1_vtx_ff;
   logic       mm_in_rdy;

   assign s1_rdy = !s1_v_ff || mm_in_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_rdy) begin
         s1_v_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_infl_ff <= cur_infl;
         s1_vtx_ff  <= vtx_ff;
      end
   end

   // Per-influence product and weighting pipeline.
   logic               mm_v;
   logic               acc_rdy;
   logic signed [33:0] mm_term [ELEMS];
   infl_type           mm_infl;
   vertex_type         mm_vtx;

   lbs_matmul #(.FRAC_BITS(FRAC_BITS)) u_matmul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_v_ff),
      .in_ready  (mm_in_rdy),
      .in_a      (ib_data),
      .in_b      (ps_data),
      .in_infl   (s1_infl_ff),
      .in_vtx    (s1_vtx_ff),
      .out_valid (mm_v),
      .out_ready (acc_rdy),
      .out_term  (mm_term),
      .out_infl  (mm_infl),
      .out_vtx   (mm_vtx)
   );

   // Skin accumulator: the first influence loads it, the last one releases the sum.
   logic               acc_v_ff;
   logic signed [35:0] acc_ff [ELEMS];
   vertex_type         acc_vtx_ff;
   logic               xf_rdy;

   assign acc_rdy = !acc_v_ff || xf_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_v_ff <= 1'b0;
      end else if (acc_rdy) begin
         acc_v_ff <= mm_v && mm_infl.last;
      end
   end

   always_ff @(posedge clock) begin
      if (acc_rdy && mm_v) begin
         for (int e = 0; e < ELEMS; e++) begin
            if (mm_infl.first) begin
               acc_ff[e] <= 36'(mm_term[e]);
            end else begin
               acc_ff[e] <= acc_ff[e] + 36'(mm_term[e]);
            end
         end
         acc_vtx_ff <= mm_vtx;
      end
   end

   // Vertex transform and output register.
   vertex_type res;

   lbs_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (acc_v_ff),
      .in_ready  (xf_rdy),
      .in_acc    (acc_ff),
      .in_vtx    (acc_vtx_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (res)
   );

   assign rsp_tdata = {res.nrm_z, res.nrm_y, res.nrm_x, res.pos_z, res.pos_y, res.pos_x};
endmodule
`default_nettype wire
